@@ rtl/core/obcw_pkg.sv @@
// ----------------------------------------------------------------------------
// obcw_pkg
// Types and constants shared by the box corner transform.
// ----------------------------------------------------------------------------
package obcw_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 48;

  localparam logic [CfgIdxW-1:0] CFG_ROT_X   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROT_Y   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROT_Z   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT_X = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT_Y = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT_Z = 3'd5;

  localparam logic signed [17:0] HalfPiQ13 = 18'sd12868;
  localparam logic signed [17:0] PiQ13     = 18'sd25736;
  localparam logic signed [17:0] TwoPiQ13  = 18'sd51472;

  localparam logic [1:0] SUB_UNKNOWN = 2'd3;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        size_along;
    logic [30:0]        size_across;
    logic [30:0]        box_height;
    logic signed [15:0] raw_yaw;
    logic [7:0]         class_label;
  } box_t;

  typedef struct packed {
    logic [2:0]         corner_number;
    logic signed [31:0] local_x;
    logic signed [31:0] local_y;
    logic signed [31:0] local_z;
    logic signed [47:0] world_x;
    logic signed [47:0] world_y;
    logic signed [47:0] world_z;
    logic signed [15:0] heading;
    logic signed [15:0] heading_cos;
    logic signed [15:0] heading_sin;
    logic [1:0]         subtype_code;
    logic               last_corner;
  } corner_t;

endpackage

@@ rtl/core/oriented_box_corners_to_world.sv @@
// ----------------------------------------------------------------------------
// oriented_box_corners_to_world
// Eight world-frame corners of an oriented 3-D box.
// ----------------------------------------------------------------------------
//  channel   signals                          role
//  box       start, busy, box_i               one box word in
//  corner    corner_valid_o, corner_o         eight corner words out
//  config    cfg_we_i, cfg_idx_i, cfg_data_i  pose register write
//
// The corner sequencer issues one corner per cycle, eight per box; busy is high
// after each accepted box until the hold counter runs out, so no new box is taken.
// Corner words leave after the trig and corner pipelines, in corner order.
// Reset clears valids and the pose to identity. Results cannot be stalled.
// ----------------------------------------------------------------------------
module oriented_box_corners_to_world (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  obcw_pkg::box_t              box_i,
  output logic                        corner_valid_o,
  output obcw_pkg::corner_t           corner_o,
  input  logic                        cfg_we_i,
  input  logic [obcw_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [obcw_pkg::CfgW-1:0]   cfg_data_i
);
  import obcw_pkg::*;

  logic [47:0] rot_x_q, rot_y_q, rot_z_q, sh_x_q, sh_y_q, sh_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_x_q <= 48'd16384;
      rot_y_q <= 48'd1073741824;
      rot_z_q <= 48'd70368744177664;
      sh_x_q  <= '0;
      sh_y_q  <= '0;
      sh_z_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROT_X:   rot_x_q <= cfg_data_i;
        CFG_ROT_Y:   rot_y_q <= cfg_data_i;
        CFG_ROT_Z:   rot_z_q <= cfg_data_i;
        CFG_SHIFT_X: sh_x_q  <= cfg_data_i;
        CFG_SHIFT_Y: sh_y_q  <= cfg_data_i;
        CFG_SHIFT_Z: sh_z_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic               tv_w;
  box_t               tb_w;
  logic signed [15:0] th_w, tc_w, ts_w;

  obcw_trig u_trig (
    .clk_i, .rst_ni,
    .valid_i   (start && !busy),
    .box_i     (box_i),
    .valid_o   (tv_w),
    .box_o     (tb_w),
    .heading_o (th_w),
    .cos_o     (tc_w),
    .sin_o     (ts_w)
  );

  // hold busy after each accepted box so its corners issue before the next box
  logic [2:0] kin_q;
  logic       act_q;
  logic [3:0] hold_q;
  box_t               sb_q;
  logic signed [15:0] sh_q, sc_q, ss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      kin_q  <= '0;
      hold_q <= '0;
    end else begin
      if (start && !busy) hold_q <= 4'd7;
      else if (hold_q != 4'd0) hold_q <= hold_q - 4'd1;
      if (tv_w) begin
        act_q <= 1'b1;
        kin_q <= 3'd1;
      end else if (act_q) begin
        kin_q <= kin_q + 3'd1;
        if (kin_q == 3'd7) act_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tv_w) begin
      sb_q <= tb_w;
      sh_q <= th_w;
      sc_q <= tc_w;
      ss_q <= ts_w;
    end
  end

  assign busy = (hold_q != 4'd0);

  logic               cv_w;
  logic [2:0]         ck_w;
  box_t               cb_w;
  logic signed [15:0] ch_w, cc_w, cs_w;

  assign cv_w = tv_w || act_q;
  assign ck_w = tv_w ? 3'd0 : kin_q;
  assign cb_w = tv_w ? tb_w : sb_q;
  assign ch_w = tv_w ? th_w : sh_q;
  assign cc_w = tv_w ? tc_w : sc_q;
  assign cs_w = tv_w ? ts_w : ss_q;

  obcw_corner u_corner (
    .clk_i, .rst_ni,
    .valid_i   (cv_w),
    .k_i       (ck_w),
    .box_i     (cb_w),
    .heading_i (ch_w),
    .cos_i     (cc_w),
    .sin_i     (cs_w),
    .rot_x_i   (rot_x_q),
    .rot_y_i   (rot_y_q),
    .rot_z_i   (rot_z_q),
    .shift_x_i (sh_x_q),
    .shift_y_i (sh_y_q),
    .shift_z_i (sh_z_q),
    .valid_o   (corner_valid_o),
    .corner_o  (corner_o)
  );

endmodule

@@ rtl/core/obcw_trig.sv @@
// ----------------------------------------------------------------------------
// obcw_trig
// Pipelined heading, cosine and sine; each Horner step has its own stage.
// ----------------------------------------------------------------------------
module obcw_trig (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  obcw_pkg::box_t     box_i,
  output logic               valid_o,
  output obcw_pkg::box_t     box_o,
  output logic signed [15:0] heading_o,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);
  import obcw_pkg::*;

  localparam int unsigned NSt = 8;

  logic signed [17:0] yaw_w, wrap_w, hd_w, red_w;
  logic               neg_w;

  always_comb begin
    yaw_w = 18'(2 * box_i.raw_yaw) + HalfPiQ13;
    if (yaw_w > PiQ13 + TwoPiQ13) begin
      wrap_w = yaw_w - TwoPiQ13 - TwoPiQ13;
    end else if (yaw_w > PiQ13) begin
      wrap_w = yaw_w - TwoPiQ13;
    end else if (yaw_w <= -PiQ13) begin
      wrap_w = yaw_w + TwoPiQ13;
    end else begin
      wrap_w = yaw_w;
    end
    hd_w = -wrap_w;
    if (hd_w > HalfPiQ13) begin
      red_w = hd_w - PiQ13;
      neg_w = 1'b1;
    end else if (hd_w < -HalfPiQ13) begin
      red_w = hd_w + PiQ13;
      neg_w = 1'b1;
    end else begin
      red_w = hd_w;
      neg_w = 1'b0;
    end
  end

  // stage arrays
  logic               v_q   [NSt];
  box_t               b_q   [NSt];
  logic signed [15:0] hd_q  [NSt];
  logic               neg_q [NSt];
  logic signed [31:0] xq_q  [6];
  logic signed [33:0] x2_q  [1:5];
  logic signed [31:0] ts_q  [1:5];
  logic signed [31:0] tc_q  [1:NSt-1];
  logic signed [63:0] sfin_q;
  logic signed [31:0] st_q;

  function automatic logic signed [31:0] hstep(input logic signed [31:0] c,
                                               input logic signed [33:0] x2,
                                               input logic signed [31:0] t);
    logic signed [63:0] p;
    begin
      p = 64'(x2) * 64'(t);
      hstep = c - 32'(p >>> 30);
    end
  endfunction

  logic signed [63:0] sq_w;
  logic signed [31:0] sr_w, cr_w;
  logic signed [15:0] sn_w, cs_w;

  assign sq_w = 64'(xq_q[0]) * 64'(xq_q[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSt; i++) v_q[i] <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int i = 1; i < NSt; i++) v_q[i] <= v_q[i-1];
      valid_o <= v_q[NSt-1];
    end
  end

  always_ff @(posedge clk_i) begin
    b_q[0]   <= box_i;
    hd_q[0]  <= 16'(hd_w);
    neg_q[0] <= neg_w;
    xq_q[0]  <= 32'(red_w) <<< 17;
    for (int i = 1; i < NSt; i++) begin
      b_q[i]   <= b_q[i-1];
      hd_q[i]  <= hd_q[i-1];
      neg_q[i] <= neg_q[i-1];
    end
    for (int i = 1; i < 6; i++) xq_q[i] <= xq_q[i-1];
    x2_q[1] <= 34'(sq_w >>> 30);
    for (int i = 2; i < 6; i++) x2_q[i] <= x2_q[i-1];
    ts_q[1] <= 32'sd2959;
    tc_q[1] <= 32'sd296;
    ts_q[2] <= hstep(32'sd213044, x2_q[1], ts_q[1]);
    tc_q[2] <= hstep(32'sd26631, x2_q[1], tc_q[1]);
    ts_q[3] <= hstep(32'sd8947849, x2_q[2], ts_q[2]);
    tc_q[3] <= hstep(32'sd1491308, x2_q[2], tc_q[2]);
    ts_q[4] <= hstep(32'sd178956971, x2_q[3], ts_q[3]);
    tc_q[4] <= hstep(32'sd44739243, x2_q[3], tc_q[3]);
    ts_q[5] <= hstep(32'sd1073741824, x2_q[4], ts_q[4]);
    tc_q[5] <= hstep(32'sd536870912, x2_q[4], tc_q[4]);
    sfin_q  <= 64'(xq_q[5]) * 64'(ts_q[5]);
    tc_q[6] <= hstep(32'sd1073741824, x2_q[5], tc_q[5]);
    st_q    <= 32'(sfin_q >>> 30);
    tc_q[7] <= tc_q[6];
  end

  function automatic logic signed [15:0] rnd(input logic signed [31:0] t);
    logic signed [32:0] r;
    begin
      r = (33'(t) + 33'sd32768) >>> 16;
      if (r > 33'sd16384) rnd = 16'sd16384;
      else if (r < -33'sd16384) rnd = -16'sd16384;
      else rnd = 16'(r);
    end
  endfunction

  assign sr_w = st_q;
  assign cr_w = tc_q[NSt-1];
  assign sn_w = rnd(sr_w);
  assign cs_w = rnd(cr_w);

  always_ff @(posedge clk_i) begin
    box_o     <= b_q[NSt-1];
    heading_o <= hd_q[NSt-1];
    sin_o     <= neg_q[NSt-1] ? -sn_w : sn_w;
    cos_o     <= neg_q[NSt-1] ? -cs_w : cs_w;
  end

endmodule

@@ rtl/core/obcw_corner.sv @@
// ----------------------------------------------------------------------------
// obcw_corner
// Pipelined corner rotation, translation and pose transform.
// ----------------------------------------------------------------------------
module obcw_corner (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [2:0]          k_i,
  input  obcw_pkg::box_t      box_i,
  input  logic signed [15:0]  heading_i,
  input  logic signed [15:0]  cos_i,
  input  logic signed [15:0]  sin_i,
  input  logic [47:0]         rot_x_i,
  input  logic [47:0]         rot_y_i,
  input  logic [47:0]         rot_z_i,
  input  logic signed [47:0]  shift_x_i,
  input  logic signed [47:0]  shift_y_i,
  input  logic signed [47:0]  shift_z_i,
  output logic                valid_o,
  output obcw_pkg::corner_t   corner_o
);
  import obcw_pkg::*;

  // stage 1: offsets and products
  logic               v1_q, v2_q, v3_q, v4_q;
  corner_t            c1_q, c2_q, c3_q, c4_q;
  corner_t            c2_d, c4_d;
  logic signed [31:0] cx1_q, cy1_q;
  logic signed [47:0] pcx_q, psy_q, psx_q, pcy_q;
  logic signed [32:0] lz_w;
  logic signed [31:0] vx_w, vy_w;

  assign vx_w = k_i[2] ? -32'(box_i.size_along) : 32'(box_i.size_along);
  assign vy_w = k_i[1] ? -32'(box_i.size_across) : 32'(box_i.size_across);
  assign lz_w = 33'(box_i.center_z) + (k_i[0] ? 33'(box_i.box_height) : 33'sd0);

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -50'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = 32'(v);
  endfunction

  always_ff @(posedge clk_i) begin
    c1_q.corner_number <= k_i;
    c1_q.heading       <= heading_i;
    c1_q.heading_cos   <= cos_i;
    c1_q.heading_sin   <= sin_i;
    c1_q.subtype_code  <= (box_i.class_label <= 8'd2) ? 2'(box_i.class_label) : SUB_UNKNOWN;
    c1_q.last_corner   <= (k_i == 3'd7);
    c1_q.local_x       <= '0;
    c1_q.local_y       <= '0;
    c1_q.local_z       <= lz_w > 33'sd2147483647 ? 32'sh7fffffff :
                          (lz_w < -33'sd2147483648 ? 32'sh80000000 : 32'(lz_w));
    c1_q.world_x       <= '0;
    c1_q.world_y       <= '0;
    c1_q.world_z       <= '0;
    cx1_q <= box_i.center_x;
    cy1_q <= box_i.center_y;
    pcx_q <= 48'(cos_i) * 48'(vx_w);
    psy_q <= 48'(sin_i) * 48'(vy_w);
    psx_q <= 48'(sin_i) * 48'(vx_w);
    pcy_q <= 48'(cos_i) * 48'(vy_w);
  end

  // stage 2: local corner
  logic signed [49:0] ax_w, ay_w;
  assign ax_w = ((50'(cx1_q) <<< 15) + 50'(pcx_q) - 50'(psy_q) + 50'sd16384) >>> 15;
  assign ay_w = ((50'(cy1_q) <<< 15) + 50'(psx_q) + 50'(pcy_q) + 50'sd16384) >>> 15;

  always_comb begin
    c2_d         = c1_q;
    c2_d.local_x = sat32(ax_w);
    c2_d.local_y = sat32(ay_w);
  end

  always_ff @(posedge clk_i) begin
    c2_q <= c2_d;
  end

  // stage 3: pose products
  logic signed [47:0] m_q [3][3];
  logic [47:0]        rows_w [3];
  assign rows_w[0] = rot_x_i;
  assign rows_w[1] = rot_y_i;
  assign rows_w[2] = rot_z_i;

  always_ff @(posedge clk_i) begin
    c3_q <= c2_q;
    for (int r = 0; r < 3; r++) begin
      m_q[r][0] <= 48'($signed(rows_w[r][15:0])) * 48'(c2_q.local_x);
      m_q[r][1] <= 48'($signed(rows_w[r][31:16])) * 48'(c2_q.local_y);
      m_q[r][2] <= 48'($signed(rows_w[r][47:32])) * 48'(c2_q.local_z);
    end
  end

  // stage 4: sum, round, saturate
  function automatic logic signed [47:0] wax(input logic signed [47:0] a,
                                             input logic signed [47:0] b,
                                             input logic signed [47:0] c,
                                             input logic signed [47:0] s);
    logic signed [63:0] acc;
    begin
      acc = ((64'(a) + 64'(b) + 64'(c) + (64'(s) <<< 14) + 64'sd8192) >>> 14);
      if (acc > 64'sd140737488355327) wax = 48'sh7fffffffffff;
      else if (acc < -64'sd140737488355328) wax = 48'sh800000000000;
      else wax = 48'(acc);
    end
  endfunction

  always_comb begin
    c4_d         = c3_q;
    c4_d.world_x = wax(m_q[0][0], m_q[0][1], m_q[0][2], shift_x_i);
    c4_d.world_y = wax(m_q[1][0], m_q[1][1], m_q[1][2], shift_y_i);
    c4_d.world_z = wax(m_q[2][0], m_q[2][1], m_q[2][2], shift_z_i);
  end

  always_ff @(posedge clk_i) begin
    c4_q <= c4_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign valid_o  = v4_q;
  assign corner_o = c4_q;

endmodule
